// File: hdl/skp_pkg.sv
// Shared types and constants for the scalar Kalman position filter.
package skp_pkg;

   // Field and register widths.
   localparam int DATA_W   = 32;
   localparam int NOISE_W  = 25;
   localparam int ADDR_W   = 2;
   localparam int GAIN_W   = 16;
   localparam int DIV_W    = 33;
   localparam int PROD_W   = 52;
   localparam int CNT_W    = 4;

   // Reset values of the registers and the variance state.
   localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET = 25'd196608;
   localparam logic [NOISE_W-1:0] MEAS_NOISE_RESET    = 25'd1048576;
   localparam logic [DATA_W-1:0]  VARIANCE_RESET      = 32'd65536;

   // Arithmetic limits.
   localparam logic [GAIN_W-1:0]  GAIN_MAX   = 16'hFFFF;
   localparam logic [DATA_W-1:0]  VAR_MAX    = 32'hFFFF_FFFF;
   localparam logic [GAIN_W:0]    ONE_Q16    = 17'h1_0000;
   localparam logic [CNT_W-1:0]   DIV_LAST   = 4'd15;

   // Configuration register indexes.
   localparam logic [ADDR_W-1:0] CSR_PROCESS_NOISE = 2'd0;
   localparam logic [ADDR_W-1:0] CSR_MEAS_NOISE    = 2'd1;

   // Operand select for the shared multiplier.
   typedef enum logic [1:0] {
      SEL_X   = 2'd0,
      SEL_Y   = 2'd1,
      SEL_Z   = 2'd2,
      SEL_VAR = 2'd3
   } skp_sel_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_GAIN,
      ST_MUL,
      ST_WB,
      ST_OUT
   } skp_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        setup;
      logic        div_step;
      logic        gain_load;
      logic        mul_en;
      logic        wb_en;
      skp_sel_type sel;
      logic        out_load;
   } skp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } skp_status_type;

endpackage

// File: hdl/skp_if.sv
// Channel interfaces: measurement input, estimate result and register writes.
interface skp_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [skp_pkg::DATA_W-1:0] velocity;
   logic signed [skp_pkg::DATA_W-1:0] accel;
   logic signed [skp_pkg::DATA_W-1:0] meas_x;
   logic signed [skp_pkg::DATA_W-1:0] meas_y;
   logic signed [skp_pkg::DATA_W-1:0] meas_z;

   modport source (output valid, velocity, accel, meas_x, meas_y, meas_z, input ready);
   modport sink (input valid, velocity, accel, meas_x, meas_y, meas_z, output ready);
endinterface

interface skp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [skp_pkg::DATA_W-1:0] est_x;
   logic signed [skp_pkg::DATA_W-1:0] est_y;
   logic signed [skp_pkg::DATA_W-1:0] est_z;
   logic        [skp_pkg::DATA_W-1:0] est_variance;

   modport source (output valid, est_x, est_y, est_z, est_variance, input ready);
   modport sink (input valid, est_x, est_y, est_z, est_variance, output ready);
endinterface

interface skp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [skp_pkg::ADDR_W-1:0]        addr;
   logic [skp_pkg::DATA_W-1:0]        wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

// File: hdl/skp_ctrl.sv
// Controller state machine that sequences predict, divide, multiply and output.
module skp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  skp_pkg::skp_status_type status,
   output skp_pkg::skp_cmd_type    cmd
);

   skp_pkg::skp_state_type state_ff, state_in;
   logic [skp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   skp_pkg::skp_sel_type      sel_ff, sel_in;

   // State, step counter and operand select registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skp_pkg::ST_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= skp_pkg::SEL_X;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      sel_in        = sel_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.sel       = sel_ff;
      case (state_ff)
         skp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = skp_pkg::ST_SETUP;
            end
         end
         skp_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = '0;
            state_in  = skp_pkg::ST_DIV;
         end
         skp_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == skp_pkg::DIV_LAST) begin
               state_in = skp_pkg::ST_GAIN;
            end
         end
         skp_pkg::ST_GAIN: begin
            cmd.gain_load = 1'b1;
            sel_in        = skp_pkg::SEL_X;
            state_in      = skp_pkg::ST_MUL;
         end
         skp_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = skp_pkg::ST_WB;
         end
         skp_pkg::ST_WB: begin
            cmd.wb_en = 1'b1;
            if (sel_ff == skp_pkg::SEL_VAR) begin
               state_in = skp_pkg::ST_OUT;
            end else begin
               sel_in   = skp_pkg::skp_sel_type'(sel_ff + 2'd1);
               state_in = skp_pkg::ST_MUL;
            end
         end
         skp_pkg::ST_OUT: begin
            // Hold the finished estimate until the output register is free.
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = skp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/skp_dp.sv
// Datapath: filter state, registers, shift-subtract divider and shared multiplier.
module skp_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  skp_pkg::skp_cmd_type              cmd,
   output skp_pkg::skp_status_type           status,
   input  logic signed [skp_pkg::DATA_W-1:0] velocity,
   input  logic signed [skp_pkg::DATA_W-1:0] accel,
   input  logic signed [skp_pkg::DATA_W-1:0] meas_x,
   input  logic signed [skp_pkg::DATA_W-1:0] meas_y,
   input  logic signed [skp_pkg::DATA_W-1:0] meas_z,
   input  logic                              csr_we,
   input  logic [skp_pkg::ADDR_W-1:0]        csr_addr,
   input  logic [skp_pkg::DATA_W-1:0]        csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [skp_pkg::DATA_W-1:0] est_x,
   output logic signed [skp_pkg::DATA_W-1:0] est_y,
   output logic signed [skp_pkg::DATA_W-1:0] est_z,
   output logic [skp_pkg::DATA_W-1:0]        est_variance
);

   localparam int W = skp_pkg::DATA_W;

   // Configuration and filter state.
   logic [skp_pkg::NOISE_W-1:0] pn_ff;
   logic [skp_pkg::NOISE_W-1:0] mn_ff;
   logic signed [W-1:0]         pos_x_ff, pos_y_ff, pos_z_ff;
   logic [W-1:0]                variance_ff;
   logic                        rsp_valid_ff;

   // Per-item working registers.
   logic signed [W-1:0]             pred_x_ff, pred_y_ff, pred_z_ff;
   logic signed [W-1:0]             mx_ff, my_ff, mz_ff;
   logic [W-1:0]                    var_ff;
   logic [skp_pkg::DIV_W-1:0]       div_ff;
   logic [skp_pkg::DIV_W-1:0]       rem_ff;
   logic [skp_pkg::GAIN_W-1:0]      quo_ff;
   logic [skp_pkg::GAIN_W-1:0]      gain_ff;
   logic signed [skp_pkg::PROD_W-1:0] prod_ff;
   logic signed [W-1:0]             out_x_ff, out_y_ff, out_z_ff;
   logic [W-1:0]                    out_var_ff;

   // Prediction: step is velocity plus half the acceleration, floored.
   logic signed [W+1:0] step;
   logic signed [W-1:0] pred_x_in, pred_y_in, pred_z_in;
   logic [W:0]          var_sum;
   logic [W-1:0]        var_in;

   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] base,
                                                    input logic signed [W+3:0] delta);
      logic signed [W+3:0] sum;
      logic signed [W+3:0] hi;
      logic signed [W+3:0] lo;
      hi  = (W+4)'({1'b0, {(W-1){1'b1}}});
      lo  = -hi - (W+4)'(1);
      sum = (W+4)'(base) + delta;
      if (sum > hi) begin
         sat_add = {1'b0, {(W-1){1'b1}}};
      end else if (sum < lo) begin
         sat_add = {1'b1, {(W-1){1'b0}}};
      end else begin
         sat_add = sum[W-1:0];
      end
   endfunction

   always_comb begin
      step      = (W+2)'(velocity) + (W+2)'(accel >>> 1);
      pred_x_in = sat_add(pos_x_ff, (W+4)'(step));
      pred_y_in = sat_add(pos_y_ff, (W+4)'(step));
      pred_z_in = sat_add(pos_z_ff, (W+4)'(step));
      var_sum   = {1'b0, variance_ff} + (W+1)'(pn_ff);
      var_in    = var_sum[W] ? skp_pkg::VAR_MAX : var_sum[W-1:0];
   end

   // One restoring divide step: shift the remainder and try the divisor.
   logic [skp_pkg::DIV_W:0]   rem_sh;
   logic                      fits;
   logic [skp_pkg::DIV_W-1:0] rem_in;
   logic [skp_pkg::GAIN_W-1:0] gain_in;

   always_comb begin
      rem_sh = {rem_ff, 1'b0};
      fits   = rem_sh >= {1'b0, div_ff};
      rem_in = fits ? skp_pkg::DIV_W'(rem_sh - {1'b0, div_ff})
                    : rem_sh[skp_pkg::DIV_W-1:0];
      // With no measurement noise the exact gain is one (or zero for zero variance).
      if (mn_ff == '0) begin
         gain_in = (var_ff != '0) ? skp_pkg::GAIN_MAX : '0;
      end else begin
         gain_in = quo_ff;
      end
   end

   // Shared multiplier operands: gain times innovation, or variance times (1 - gain).
   logic signed [W+1:0]  mul_a;
   logic signed [17:0]   mul_b;
   logic signed [W:0]    diff_x, diff_y, diff_z;

   always_comb begin
      diff_x = (W+1)'(mx_ff) - (W+1)'(pred_x_ff);
      diff_y = (W+1)'(my_ff) - (W+1)'(pred_y_ff);
      diff_z = (W+1)'(mz_ff) - (W+1)'(pred_z_ff);
      mul_b  = $signed({2'b00, gain_ff});
      case (cmd.sel)
         skp_pkg::SEL_X:   mul_a = (W+2)'(diff_x);
         skp_pkg::SEL_Y:   mul_a = (W+2)'(diff_y);
         skp_pkg::SEL_Z:   mul_a = (W+2)'(diff_z);
         skp_pkg::SEL_VAR: begin
            mul_a = $signed({2'b00, var_ff});
            mul_b = $signed({1'b0, 17'(skp_pkg::ONE_Q16 - {1'b0, gain_ff})});
         end
         default:          mul_a = '0;
      endcase
   end

   // Write back: predicted position plus floored correction, saturated.
   logic signed [W+3:0] corr;
   logic signed [W-1:0] new_x, new_y, new_z;

   always_comb begin
      corr  = prod_ff[skp_pkg::PROD_W-1:16];
      new_x = sat_add(pred_x_ff, corr);
      new_y = sat_add(pred_y_ff, corr);
      new_z = sat_add(pred_z_ff, corr);
   end

   // Configuration, filter state and output handshake registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pn_ff        <= skp_pkg::PROCESS_NOISE_RESET;
         mn_ff        <= skp_pkg::MEAS_NOISE_RESET;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         variance_ff  <= skp_pkg::VARIANCE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               skp_pkg::CSR_PROCESS_NOISE: pn_ff <= csr_wdata[skp_pkg::NOISE_W-1:0];
               skp_pkg::CSR_MEAS_NOISE:    mn_ff <= csr_wdata[skp_pkg::NOISE_W-1:0];
               default: ;
            endcase
         end
         if (cmd.wb_en) begin
            case (cmd.sel)
               skp_pkg::SEL_X:   pos_x_ff    <= new_x;
               skp_pkg::SEL_Y:   pos_y_ff    <= new_y;
               skp_pkg::SEL_Z:   pos_z_ff    <= new_z;
               skp_pkg::SEL_VAR: variance_ff <= prod_ff[W+15:16];
               default: ;
            endcase
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers for one item.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pred_x_ff <= pred_x_in;
         pred_y_ff <= pred_y_in;
         pred_z_ff <= pred_z_in;
         mx_ff     <= meas_x;
         my_ff     <= meas_y;
         mz_ff     <= meas_z;
         var_ff    <= var_in;
      end
      if (cmd.setup) begin
         div_ff <= {1'b0, var_ff} + skp_pkg::DIV_W'(mn_ff);
         rem_ff <= {1'b0, var_ff};
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[skp_pkg::GAIN_W-2:0], fits};
      end
      if (cmd.gain_load) begin
         gain_ff <= gain_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.out_load) begin
         out_x_ff   <= pos_x_ff;
         out_y_ff   <= pos_y_ff;
         out_z_ff   <= pos_z_ff;
         out_var_ff <= variance_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign est_x           = out_x_ff;
   assign est_y           = out_y_ff;
   assign est_z           = out_z_ff;
   assign est_variance    = out_var_ff;

endmodule

// File: hdl/scalar_kalman_position_3d.sv
// Top level of the scalar Kalman filter for a three-axis position.
//
// Usage: each transfer on req_if carries a velocity, an acceleration and a
// measured x, y, z position, all signed Q16.16. For each one the block
// predicts and then corrects its three position estimates and the shared
// variance, and presents one transfer on rsp_if with the corrected values.
// Register writes arrive on csr_if (index 0: process noise, index 1:
// measurement noise, both unsigned Q16.16, masked to 25 bits); csr_if is
// always ready. Writes must be made while no item is in flight; the block
// itself does not enforce this. One item is worked on at a time, so a new
// input is taken only once the previous result has been loaded into the
// output register. Each item takes a 16-step shift-subtract divide for the
// gain and four passes through the one shared multiplier.
// Reset (synchronous, active high) clears the estimates to zero, sets the
// variance to 1.0 and the noise registers to 3.0 and 16.0.
// A finished result waits in the output register while rsp_if is stalled;
// the next input is still taken and worked on, and its result is held back
// until the output register frees up.
module scalar_kalman_position_3d (
   input  logic  clock,
   input  logic  reset,
   skp_req_if.sink   req_if,
   skp_rsp_if.source rsp_if,
   skp_csr_if.sink   csr_if
);

   skp_pkg::skp_cmd_type    cmd;
   skp_pkg::skp_status_type status;

   // Register writes are always taken.
   assign csr_if.ready = 1'b1;

   skp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   skp_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .velocity     (req_if.velocity),
      .accel        (req_if.accel),
      .meas_x       (req_if.meas_x),
      .meas_y       (req_if.meas_y),
      .meas_z       (req_if.meas_z),
      .csr_we       (csr_if.valid),
      .csr_addr     (csr_if.addr),
      .csr_wdata    (csr_if.wdata),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .est_x        (rsp_if.est_x),
      .est_y        (rsp_if.est_y),
      .est_z        (rsp_if.est_z),
      .est_variance (rsp_if.est_variance)
   );

endmodule
